[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the CSV tokenizer; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// next-cycle implication
`define CSVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define CSVT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSVT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/csvt_pkg.sv]
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared characters, token types and helpers for the CSV tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int TOKQ_DEPTH = 4;

  typedef enum logic [1:0] {
    TK_CHAR       = 2'd0,
    TK_FIELD_END  = 2'd1,
    TK_RECORD_END = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  char_value;
    logic [7:0]  field_index;
    logic        blank_record;
    logic        last_of_run;
  } token_t;

  // tokens caused by one item, first in order; count is 0..2
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_pair_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
               (c == 8'h85) || (c == 8'hA0);
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

[rtl/csvt_channels.sv]
// ----------------------------------------------------------------------------
// csvt_channels
// Valid/ready channels for text characters and tokens.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] char_value;
  logic [7:0] field_index;
  logic       blank_record;
  logic       last_of_run;

  modport source (output valid, token_kind, char_value, field_index, blank_record,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, char_value, field_index, blank_record,
                  last_of_run, output ready);
endinterface

[rtl/csvt_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// csv_tokenizer_top
// CSV tokenizer: one character per item in, field/record tokens out.
//
//   channel   dir  payload                                           handshake
//   in_chan   in   char_code[7:0], end_of_text                       valid/ready
//   out_chan  out  token_kind[1:0], char_value[7:0], field_index[7:0], valid/ready
//                  blank_record, last_of_run
//
// One item per cycle while in_chan.ready is high; a character is parsed in the
// cycle it is accepted and its tokens (0..2) land in a 4-entry token queue read
// one per cycle while out_chan.ready is high. Two-token items are output-paced.
// in_chan.ready is high while the queue holds at most two tokens.
// Synchronous active-low reset clears parse state and the queue.
// ----------------------------------------------------------------------------
module csv_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  csvt_in_if.sink    in_chan,
  csvt_out_if.source out_chan
);
  import csvt_pkg::*;

  logic      advance;
  logic      room_for_pair;
  logic      pop;
  tok_pair_t tokens;
  token_t    head;

  assign in_chan.ready = room_for_pair;
  assign advance       = in_chan.valid && room_for_pair;
  assign pop           = out_chan.valid && out_chan.ready;

  csvt_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .char_code   (in_chan.char_code),
    .end_of_text (in_chan.end_of_text),
    .tokens      (tokens)
  );

  csvt_tok_fifo u_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (advance),
    .tokens        (tokens),
    .pop           (pop),
    .head          (head),
    .not_empty     (out_chan.valid),
    .room_for_pair (room_for_pair)
  );

  assign out_chan.token_kind   = head.kind;
  assign out_chan.char_value   = head.char_value;
  assign out_chan.field_index  = head.field_index;
  assign out_chan.blank_record = head.blank_record;
  assign out_chan.last_of_run  = head.last_of_run;

endmodule

[rtl/csvt_parser.sv]
// ----------------------------------------------------------------------------
// csvt_parser
// Parse state and token generation for one character per accepted item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          char_code,
  input  logic                end_of_text,
  output csvt_pkg::tok_pair_t tokens
);
  import csvt_pkg::*;

  logic       inside_quotes_r, inside_quotes_nxt;
  logic       quote_pending_r, quote_pending_nxt;
  logic       skip_next_lf_r, skip_next_lf_nxt;
  logic [7:0] fields_done_r, fields_done_nxt;
  logic       field_nonempty_r, field_nonempty_nxt;
  logic       field_all_space_r, field_all_space_nxt;

  logic       uq, is_q, q_char, fc, ef, er;
  logic [7:0] fd1;
  logic       ne1, as1, t2_v;
  token_t     t1, t2;

  always_comb begin
    is_q   = (char_code == CH_QUOTE);
    // character goes through the unquoted rules
    if (skip_next_lf_r) begin
      uq = (char_code != CH_LF);
    end else if (quote_pending_r) begin
      uq = !is_q;
    end else begin
      uq = !inside_quotes_r;
    end
    q_char = (quote_pending_r && is_q) ||
             (!skip_next_lf_r && !quote_pending_r && inside_quotes_r && !is_q);
    ef = uq && (char_code == CH_COMMA);
    er = uq && ((char_code == CH_LF) || (char_code == CH_CR));
    fc = q_char || (uq && !is_q && !ef && !er);

    fd1 = ef ? sat_inc(fields_done_r) : (er ? 8'd0 : fields_done_r);
    ne1 = fc ? 1'b1 : ((ef || er) ? 1'b0 : field_nonempty_r);
    as1 = fc ? (field_all_space_r && is_space(char_code)) :
               ((ef || er) ? 1'b1 : field_all_space_r);

    t1.kind         = fc ? TK_CHAR : (ef ? TK_FIELD_END : TK_RECORD_END);
    t1.char_value   = fc ? char_code : 8'd0;
    t1.field_index  = fields_done_r;
    t1.blank_record = er && (fields_done_r == 8'd0) && field_all_space_r;
    t1.last_of_run  = 1'b0;

    t2_v            = end_of_text && (ne1 || (fd1 != 8'd0));
    t2.kind         = TK_RECORD_END;
    t2.char_value   = 8'd0;
    t2.field_index  = fd1;
    t2.blank_record = (fd1 == 8'd0) && as1;
    t2.last_of_run  = 1'b1;

    if (fc || ef || er) begin
      tokens.count             = t2_v ? 2'd2 : 2'd1;
      tokens.first             = t1;
      tokens.first.last_of_run = !t2_v;
      tokens.second            = t2;
    end else begin
      tokens.count  = t2_v ? 2'd1 : 2'd0;
      tokens.first  = t2;
      tokens.second = t2;
    end
  end

  always_comb begin
    if (end_of_text) begin
      inside_quotes_nxt   = 1'b0;
      quote_pending_nxt   = 1'b0;
      skip_next_lf_nxt    = 1'b0;
      fields_done_nxt     = 8'd0;
      field_nonempty_nxt  = 1'b0;
      field_all_space_nxt = 1'b1;
    end else begin
      inside_quotes_nxt   = uq ? is_q : inside_quotes_r;
      quote_pending_nxt   = !skip_next_lf_r && !quote_pending_r && inside_quotes_r && is_q;
      skip_next_lf_nxt    = uq && (char_code == CH_CR);
      fields_done_nxt     = fd1;
      field_nonempty_nxt  = ne1;
      field_all_space_nxt = as1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r   <= 1'b0;
      quote_pending_r   <= 1'b0;
      skip_next_lf_r    <= 1'b0;
      fields_done_r     <= 8'd0;
      field_nonempty_r  <= 1'b0;
      field_all_space_r <= 1'b1;
    end else if (advance) begin
      inside_quotes_r   <= inside_quotes_nxt;
      quote_pending_r   <= quote_pending_nxt;
      skip_next_lf_r    <= skip_next_lf_nxt;
      fields_done_r     <= fields_done_nxt;
      field_nonempty_r  <= field_nonempty_nxt;
      field_all_space_r <= field_all_space_nxt;
    end
  end

  `CSVT_ASSERT_IMP(a_pending_in_quotes, clk, rst_n, quote_pending_r, inside_quotes_r)
  `CSVT_ASSERT_IMP(a_skip_outside, clk, rst_n, skip_next_lf_r, !inside_quotes_r && !quote_pending_r)
  `CSVT_ASSERT_NXT(a_eot_clears, clk, rst_n, advance && end_of_text, (fields_done_r == 8'd0) && !inside_quotes_r && !skip_next_lf_r)

endmodule

[rtl/csvt_tok_fifo.sv]
// ----------------------------------------------------------------------------
// csvt_tok_fifo
// Small token queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_tok_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csvt_pkg::tok_pair_t tokens,
  input  logic                pop,
  output csvt_pkg::token_t    head,
  output logic                not_empty,
  output logic                room_for_pair
);
  import csvt_pkg::*;

  localparam int PTR_W = $clog2(TOKQ_DEPTH);
  localparam int CNT_W = $clog2(TOKQ_DEPTH + 1);

  token_t             mem [TOKQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         push_n;

  assign push_n        = push ? tokens.count : 2'd0;
  assign head          = mem[rd_ptr_r];
  assign not_empty     = (count_r != '0);
  assign room_for_pair = (count_r <= CNT_W'(TOKQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= tokens.first;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= tokens.second;
    end
  end

  `CSVT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(TOKQ_DEPTH))
  `CSVT_ASSERT_IMP(a_push_room, clk, rst_n, push_n != 2'd0, count_r <= CNT_W'(TOKQ_DEPTH - 2))
  `CSVT_ASSERT_NXT(a_pop_only, clk, rst_n, pop && (push_n == 2'd0), count_r == $past(count_r) - CNT_W'(1))

endmodule

[dv/csv_tokenizer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_tokenizer_top_test
// Self-checking bench for the CSV tokenizer. A short stimulus table covers
// quoting, doubled quotes, CRLF, blank records and end of text. It is followed
// by random records, a 301-field record and noise. Each item's tokens are
// predicted by an in-bench tokenizer model, or taken from the table where a
// row lists them, and compared in order with what the block emits. Both sides
// idle at random, and there is one long output stall and one full drain.
// ----------------------------------------------------------------------------
module csv_tokenizer_top_test;
  import csvt_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 12;
  localparam int MAX_PRINTS  = 50;

  typedef struct {
    bit [7:0] c;
    bit       eot;
    bit       typed;
    int       n;
    token_t   t0;
    token_t   t1;
  } stim_row_t;

  logic clk;
  logic rst_n;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_tokenizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // tokenizer model state
  bit       m_in_quotes;
  bit       m_quote_pending;
  bit       m_skip_lf;
  bit [7:0] m_fields;
  bit       m_nonempty;
  bit       m_all_space;
  token_t   staged[2];
  int       staged_n;

  token_t    expected_tokens[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        tokens_seen;
  int        items_sent;
  bit        no_idle;
  bit        hold_req;

  function automatic token_t make_token(tok_kind_t k, bit [7:0] ch, bit [7:0] idx,
                                        bit blank, bit last);
    token_t t;
    t.kind         = k;
    t.char_value   = ch;
    t.field_index  = idx;
    t.blank_record = blank;
    t.last_of_run  = last;
    return t;
  endfunction

  function automatic bit blank_char(bit [7:0] c);
    case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void stage_token(token_t t);
    if (staged_n < 2) begin
      staged[staged_n] = t;
      staged_n++;
    end
  endfunction

  function automatic void clear_model();
    m_in_quotes     = 1'b0;
    m_quote_pending = 1'b0;
    m_skip_lf       = 1'b0;
    m_fields        = 8'd0;
    m_nonempty      = 1'b0;
    m_all_space     = 1'b1;
  endfunction

  function automatic void take_field_char(bit [7:0] c);
    stage_token(make_token(TK_CHAR, c, m_fields, 1'b0, 1'b0));
    m_nonempty = 1'b1;
    if (!blank_char(c)) m_all_space = 1'b0;
  endfunction

  function automatic void close_record();
    stage_token(make_token(TK_RECORD_END, 8'd0, m_fields, 1'b0,
                           1'b0));
    staged[staged_n-1].blank_record = (m_fields == 8'd0) && m_all_space;
    m_fields    = 8'd0;
    m_nonempty  = 1'b0;
    m_all_space = 1'b1;
  endfunction

  function automatic void outside_char(bit [7:0] c);
    case (c)
      CH_QUOTE: m_in_quotes = 1'b1;
      CH_COMMA: begin
        stage_token(make_token(TK_FIELD_END, 8'd0, m_fields, 1'b0, 1'b0));
        if (m_fields != 8'hFF) m_fields = m_fields + 8'd1;
        m_nonempty  = 1'b0;
        m_all_space = 1'b1;
      end
      CH_LF: close_record();
      CH_CR: begin
        close_record();
        m_skip_lf = 1'b1;
      end
      default: take_field_char(c);
    endcase
  endfunction

  // tokens for one accepted character, left in staged[0 .. staged_n-1]
  function automatic void tokenize_char(bit [7:0] c, bit eot);
    staged_n = 0;
    if (m_skip_lf) begin
      m_skip_lf = 1'b0;
      if (c != CH_LF) outside_char(c);
    end else if (m_quote_pending) begin
      m_quote_pending = 1'b0;
      if (c == CH_QUOTE) begin
        take_field_char(c);
      end else begin
        m_in_quotes = 1'b0;
        outside_char(c);
      end
    end else if (m_in_quotes) begin
      if (c == CH_QUOTE) m_quote_pending = 1'b1;
      else take_field_char(c);
    end else begin
      outside_char(c);
    end
    if (eot) begin
      if (m_nonempty || m_fields != 8'd0) close_record();
      clear_model();
    end
    if (staged_n > 0) staged[staged_n-1].last_of_run = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_row_t free_row(bit [7:0] c, bit eot);
    stim_row_t r;
    r.c     = c;
    r.eot   = eot;
    r.typed = 1'b0;
    r.n     = 0;
    r.t0    = '0;
    r.t1    = '0;
    return r;
  endfunction

  task automatic add_row(input bit [7:0] c, input bit eot, input bit typed, input int n,
                         input token_t t0, input token_t t1);
    stim_row_t r;
    r       = free_row(c, eot);
    r.typed = typed;
    r.n     = n;
    r.t0    = t0;
    r.t1    = t1;
    directed_rows.push_back(r);
  endtask

  task automatic push_item(input stim_row_t r);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tokenize_char(r.c, r.eot);
    if (r.typed) begin
      if (r.n > 0) expected_tokens.push_back(r.t0);
      if (r.n > 1) expected_tokens.push_back(r.t1);
    end else begin
      for (int k = 0; k < staged_n; k++) expected_tokens.push_back(staged[k]);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= r.c;
    in_ch.end_of_text <= r.eot;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] token %0d %s: got %0h want %0h", $time, tokens_seen, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // token checker
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", 8'(out_ch.token_kind), 8'd0);
      end else begin
        want = expected_tokens.pop_front();
        if (out_ch.token_kind !== want.kind)
          report_mismatch("token_kind", 8'(out_ch.token_kind), 8'(want.kind));
        if (out_ch.char_value !== want.char_value)
          report_mismatch("char_value", out_ch.char_value, want.char_value);
        if (out_ch.field_index !== want.field_index)
          report_mismatch("field_index", out_ch.field_index, want.field_index);
        if (out_ch.blank_record !== want.blank_record)
          report_mismatch("blank_record", 8'(out_ch.blank_record), 8'(want.blank_record));
        if (out_ch.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 8'(out_ch.last_of_run), 8'(want.last_of_run));
      end
      tokens_seen++;
    end
  end

  // token receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // character sender
  initial begin
    int       r;
    int       nf;
    int       flen;
    int       term;
    bit       quoted;
    bit       did_hold;
    bit       did_drain;
    bit [7:0] c;
    bit [7:0] line[$];

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = 8'd0;
    in_ch.end_of_text = 1'b0;
    mismatch_count    = 0;
    tokens_seen       = 0;
    items_sent        = 0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    did_hold          = 1'b0;
    did_drain         = 1'b0;
    clear_model();

    add_row("a",      1'b0, 1'b1, 1, make_token(TK_CHAR, "a", 8'd0, 1'b0, 1'b1), '0);
    add_row(CH_COMMA, 1'b0, 1'b1, 1, make_token(TK_FIELD_END, 8'd0, 8'd0, 1'b0, 1'b1), '0);
    add_row(CH_QUOTE, 1'b0, 1'b1, 0, '0, '0);
    add_row(CH_COMMA, 1'b0, 1'b0, 0, '0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row("x",      1'b0, 1'b0, 0, '0, '0);
    add_row(CH_CR,    1'b0, 1'b0, 0, '0, '0);
    add_row(CH_LF,    1'b0, 1'b1, 0, '0, '0);
    add_row(8'h20,    1'b0, 1'b0, 0, '0, '0);
    add_row(CH_LF,    1'b0, 1'b0, 0, '0, '0);
    add_row(CH_LF,    1'b0, 1'b1, 1, make_token(TK_RECORD_END, 8'd0, 8'd0, 1'b1, 1'b1), '0);
    add_row(8'hFF,    1'b0, 1'b1, 1, make_token(TK_CHAR, 8'hFF, 8'd0, 1'b0, 1'b1), '0);
    add_row(8'h00,    1'b1, 1'b1, 2, make_token(TK_CHAR, 8'h00, 8'd0, 1'b0, 1'b0),
            make_token(TK_RECORD_END, 8'd0, 8'd0, 1'b0, 1'b1));
    add_row(CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row(CH_QUOTE, 1'b1, 1'b1, 0, '0, '0);
    add_row(CH_COMMA, 1'b1, 1'b1, 2, make_token(TK_FIELD_END, 8'd0, 8'd0, 1'b0, 1'b0),
            make_token(TK_RECORD_END, 8'd0, 8'd1, 1'b0, 1'b1));
    add_row(CH_CR,    1'b1, 1'b0, 0, '0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 0, '0, '0);
    add_row("q",      1'b0, 1'b0, 0, '0, '0);
    add_row("r",      1'b1, 1'b0, 0, '0, '0);
    add_row(8'h85,    1'b0, 1'b0, 0, '0, '0);
    add_row(CH_CR,    1'b0, 1'b0, 0, '0, '0);
    add_row("z",      1'b0, 1'b0, 0, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) push_item(directed_rows[i]);

    while (items_sent < ITEM_TARGET) begin
      if (!did_hold && items_sent >= 700) begin
        // sender keeps offering while the output is blocked
        did_hold = 1'b1;
        hold_req = 1'b1;
      end
      if (!did_drain && items_sent >= 1000) begin
        did_drain = 1'b1;
        in_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        // field index saturation
        for (int k = 0; k < 300; k++) push_item(free_row(CH_COMMA, 1'b0));
        push_item(free_row(CH_LF, 1'b0));
        no_idle = 1'b1;
      end
      if (no_idle && items_sent >= 1500) no_idle = 1'b0;

      r = $urandom_range(0, 99);
      if (r < 75) begin
        line.delete();
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) line.push_back(CH_COMMA);
          quoted = ($urandom_range(0, 9) < 4);
          flen   = $urandom_range(0, 6);
          if (quoted) line.push_back(CH_QUOTE);
          for (int k = 0; k < flen; k++) begin
            r = $urandom_range(0, 9);
            if (quoted) begin
              c = 8'($urandom_range(0, 255));
              if (r < 2) c = CH_QUOTE;
              line.push_back(c);
              if (c == CH_QUOTE) line.push_back(CH_QUOTE);
            end else begin
              if (r < 5) begin
                c = 8'($urandom_range(8'h61, 8'h7A));
              end else if (r < 7) begin
                case ($urandom_range(0, 3))
                  0: c = 8'h20;
                  1: c = 8'h09;
                  2: c = 8'hA0;
                  default: c = 8'h85;
                endcase
              end else begin
                c = 8'($urandom_range(0, 255));
              end
              if (c == CH_QUOTE || c == CH_COMMA || c == CH_LF || c == CH_CR) c = "k";
              line.push_back(c);
            end
          end
          if (quoted) line.push_back(CH_QUOTE);
        end
        term = $urandom_range(0, 9);
        if (term < 4) begin
          line.push_back(CH_LF);
        end else if (term < 6) begin
          line.push_back(CH_CR);
        end else if (term < 8) begin
          line.push_back(CH_CR);
          line.push_back(CH_LF);
        end else if (line.size() == 0) begin
          line.push_back("e");
        end
        foreach (line[k])
          push_item(free_row(line[k], (term >= 8) && (k == line.size() - 1)));
      end else begin
        nf = $urandom_range(1, 8);
        for (int k = 0; k < nf; k++) begin
          case ($urandom_range(0, 7))
            0: c = CH_QUOTE;
            1: c = CH_COMMA;
            2: c = CH_LF;
            3: c = CH_CR;
            default: c = 8'($urandom_range(0, 255));
          endcase
          push_item(free_row(c, $urandom_range(0, 19) == 0));
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
